### rtl/core/frf_pkg.sv
// shared types, codes and constants for the port rule filter
// no dependencies
package frf_pkg;

  localparam int RULE_ENTRIES_DEF = 64;

  typedef enum logic [2:0] {
    CMD_QUERY  = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_SETEN  = 3'd3,
    CMD_MOVE   = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NO_TAG    = 3'd2,
    STAT_BAD_RANGE = 3'd3,
    STAT_BAD_INDEX = 3'd4
  } stat_t;

  typedef enum logic [1:0] {
    REASON_OFF     = 2'd0,
    REASON_MATCH   = 2'd1,
    REASON_DEFAULT = 2'd2
  } reason_t;

  typedef enum logic [1:0] {
    REG_FIREWALL_ON = 2'd0,
    REG_DEFAULT_IN  = 2'd1,
    REG_DEFAULT_OUT = 2'd2
  } reg_t;

  localparam logic [1:0] PROTO_ANY = 2'd0;

  typedef struct packed {
    logic        on;
    logic        dir;
    logic [1:0]  proto;
    logic        act;
    logic [7:0]  prog;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] tag;
  } rule_t;

  typedef enum logic {
    RA_PTR  = 1'b0,
    RA_NEXT = 1'b1
  } rsel_t;

  typedef enum logic [1:0] {
    WD_NEW  = 2'd0,
    WD_RD   = 2'd1,
    WD_EN   = 2'd2,
    WD_HOLD = 2'd3
  } wsel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_Q_RD, S_Q_CHK, S_SH_RD, S_SH_WR,
    S_SE_RD, S_SE_WR, S_MV_RD, S_MV_HOLD, S_RD_RD, S_RD_OUT, S_POST
  } state_t;

  typedef struct packed {
    logic  load;
    logic  res_init;
    logic  res_hit;
    logic  res_default;
    logic  res_read;
    logic  ptr_zero;
    logic  ptr_idx;
    logic  ptr_inc;
    logic  ptr_dec;
    logic  end_load;
    logic  mem_rd;
    rsel_t rd_sel;
    logic  mem_wr;
    wsel_t wr_sel;
    logic  hold_load;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  post;
  } frf_ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       ok;
    logic       fw_on;
    logic       scan_end;
    logic       hit;
    logic       shift_done;
    logic       up;
    logic       out_free;
  } frf_stat_t;

endpackage

### rtl/core/first_match_port_rule_filter.sv
// top level of the first match port rule filter
// depends on frf_pkg, frf_ctrl and frf_datapath
//
// Ordered rule table in a single-port memory, walked by a command sequencer. One command is
// taken at a time. Add, a query with the firewall off and any rejected command post after
// decode; set enable and read first read the rule. A query reads and checks each rule in turn
// until one matches or the table ends. Remove and move shift rules with a read and a write
// each; move holds the moved rule and writes it last. At most one memory access per cycle. A
// finished result sits in the output register and the next command can be taken while it
// waits; that command is held before posting until the waiting result has been taken.
module first_match_port_rule_filter #(
  parameter int RULE_ENTRIES = frf_pkg::RULE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              write_enable,
  input  logic [1:0]        reg_index,
  input  logic              write_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        command,
  input  logic [5:0]        index,
  input  logic signed [6:0] move_by,
  input  logic              enabled,
  input  logic              direction,
  input  logic [1:0]        protocol,
  input  logic [15:0]       port_low,
  input  logic [15:0]       port_high,
  input  logic [7:0]        program_id,
  input  logic              allow,
  input  logic [15:0]       rule_tag,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic              allowed,
  output logic [1:0]        reason,
  output logic [5:0]        match_index,
  output logic [15:0]       match_tag,
  output logic [6:0]        rule_total,
  output logic              read_enabled,
  output logic              read_direction,
  output logic [1:0]        read_protocol,
  output logic [15:0]       read_port_low,
  output logic [15:0]       read_port_high,
  output logic [7:0]        read_program
);
  import frf_pkg::*;

  frf_ctrl_t ctrl;
  frf_stat_t sts;

  frf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctrl     (ctrl)
  );

  frf_datapath #(
    .RULE_ENTRIES (RULE_ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .sts            (sts),
    .write_enable   (write_enable),
    .reg_index      (reg_index),
    .write_data     (write_data),
    .command        (command),
    .index          (index),
    .move_by        (move_by),
    .enabled        (enabled),
    .direction      (direction),
    .protocol       (protocol),
    .port_low       (port_low),
    .port_high      (port_high),
    .program_id     (program_id),
    .allow          (allow),
    .rule_tag       (rule_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .allowed        (allowed),
    .reason         (reason),
    .match_index    (match_index),
    .match_tag      (match_tag),
    .rule_total     (rule_total),
    .read_enabled   (read_enabled),
    .read_direction (read_direction),
    .read_protocol  (read_protocol),
    .read_port_low  (read_port_low),
    .read_port_high (read_port_high),
    .read_program   (read_program)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command is in progress");

  a_post_shows_result: assert property (@(posedge clk) disable iff (rst)
    ctrl.post |=> out_valid)
    else $error("posted result not presented");

  a_post_needs_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.post |-> sts.out_free)
    else $error("result posted over an untaken transfer");

  a_one_mem_access: assert property (@(posedge clk) disable iff (rst)
    ctrl.mem_wr |-> !ctrl.mem_rd)
    else $error("rule memory read and written in one cycle");
`endif

endmodule

### rtl/core/frf_ctrl.sv
// command sequencer for the port rule filter
// depends on frf_pkg
module frf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  frf_pkg::frf_stat_t sts,
  output frf_pkg::frf_ctrl_t ctrl
);
  import frf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        ctrl.res_init = 1'b1;
        state_next    = S_POST;
        case (sts.cmd)
          CMD_QUERY: begin
            if (sts.fw_on) begin
              ctrl.ptr_zero = 1'b1;
              state_next    = S_Q_RD;
            end
          end
          CMD_ADD: begin
            if (sts.ok) begin
              ctrl.mem_wr  = 1'b1;
              ctrl.wr_sel  = WD_NEW;
              ctrl.cnt_inc = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (sts.ok) begin
              ctrl.ptr_idx  = 1'b1;
              ctrl.end_load = 1'b1;
              state_next    = S_SH_RD;
            end
          end
          CMD_SETEN: begin
            if (sts.ok) begin
              ctrl.ptr_idx = 1'b1;
              state_next   = S_SE_RD;
            end
          end
          CMD_MOVE: begin
            if (sts.ok) begin
              ctrl.ptr_idx  = 1'b1;
              ctrl.end_load = 1'b1;
              state_next    = S_MV_RD;
            end
          end
          CMD_READ: begin
            if (sts.ok) begin
              ctrl.ptr_idx = 1'b1;
              state_next   = S_RD_RD;
            end
          end
          default: state_next = S_POST;
        endcase
      end
      S_Q_RD: begin
        if (sts.scan_end) begin
          ctrl.res_default = 1'b1;
          state_next       = S_POST;
        end else begin
          ctrl.mem_rd = 1'b1;
          ctrl.rd_sel = RA_PTR;
          state_next  = S_Q_CHK;
        end
      end
      S_Q_CHK: begin
        if (sts.hit) begin
          ctrl.res_hit = 1'b1;
          state_next   = S_POST;
        end else begin
          ctrl.ptr_inc = 1'b1;
          state_next   = S_Q_RD;
        end
      end
      S_SH_RD: begin
        if (sts.shift_done) begin
          if (sts.cmd == CMD_REMOVE) begin
            ctrl.cnt_dec = 1'b1;
          end else begin
            ctrl.mem_wr = 1'b1;
            ctrl.wr_sel = WD_HOLD;
          end
          state_next = S_POST;
        end else begin
          ctrl.mem_rd = 1'b1;
          ctrl.rd_sel = RA_NEXT;
          state_next  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ctrl.mem_wr  = 1'b1;
        ctrl.wr_sel  = WD_RD;
        ctrl.ptr_inc = sts.up;
        ctrl.ptr_dec = !sts.up;
        state_next   = S_SH_RD;
      end
      S_SE_RD: begin
        ctrl.mem_rd = 1'b1;
        ctrl.rd_sel = RA_PTR;
        state_next  = S_SE_WR;
      end
      S_SE_WR: begin
        ctrl.mem_wr = 1'b1;
        ctrl.wr_sel = WD_EN;
        state_next  = S_POST;
      end
      S_MV_RD: begin
        ctrl.mem_rd = 1'b1;
        ctrl.rd_sel = RA_PTR;
        state_next  = S_MV_HOLD;
      end
      S_MV_HOLD: begin
        ctrl.hold_load = 1'b1;
        state_next     = S_SH_RD;
      end
      S_RD_RD: begin
        ctrl.mem_rd = 1'b1;
        ctrl.rd_sel = RA_PTR;
        state_next  = S_RD_OUT;
      end
      S_RD_OUT: begin
        ctrl.res_read = 1'b1;
        state_next    = S_POST;
      end
      S_POST: begin
        if (sts.out_free) begin
          ctrl.post  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/core/frf_datapath.sv
// rule memory, pointers, match logic, config and result registers
// depends on frf_pkg
module frf_datapath #(
  parameter int RULE_ENTRIES = frf_pkg::RULE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  frf_pkg::frf_ctrl_t ctrl,
  output frf_pkg::frf_stat_t sts,
  input  logic               write_enable,
  input  logic [1:0]         reg_index,
  input  logic               write_data,
  input  logic [2:0]         command,
  input  logic [5:0]         index,
  input  logic signed [6:0]  move_by,
  input  logic               enabled,
  input  logic               direction,
  input  logic [1:0]         protocol,
  input  logic [15:0]        port_low,
  input  logic [15:0]        port_high,
  input  logic [7:0]         program_id,
  input  logic               allow,
  input  logic [15:0]        rule_tag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic               allowed,
  output logic [1:0]         reason,
  output logic [5:0]         match_index,
  output logic [15:0]        match_tag,
  output logic [6:0]         rule_total,
  output logic               read_enabled,
  output logic               read_direction,
  output logic [1:0]         read_protocol,
  output logic [15:0]        read_port_low,
  output logic [15:0]        read_port_high,
  output logic [7:0]         read_program
);
  import frf_pkg::*;

  localparam int AW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
  localparam int CW = $clog2(RULE_ENTRIES + 1);
  localparam int WW = ((CW > 7) ? CW : 7) + 2;

  rule_t mem [RULE_ENTRIES];

  logic [2:0]        cmd_q;
  logic [5:0]        idx_q;
  logic signed [6:0] by_q;
  logic              en_q, dir_q, act_q;
  logic [1:0]        proto_q;
  logic [15:0]       plo_q, phi_q, tag_q;
  logic [7:0]        prog_q;

  logic [CW-1:0] count, ptr, end_ptr;
  logic          up;
  rule_t         hold, rd_q, wdata;
  logic [AW-1:0] raddr, waddr;
  logic [CW-1:0] ptr_step;

  logic firewall_on, default_in, default_out;

  logic [2:0]  res_status;
  logic        res_allowed;
  logic [1:0]  res_reason;
  logic [5:0]  res_index;
  logic [15:0] res_tag;
  rule_t       res_rule;

  logic signed [WW-1:0] idx_s, by_s, to_s, cnt_s;
  logic                 idx_ok, move_ok, hit;
  logic [2:0]           code;

  always_comb begin
    idx_s   = signed'({{(WW-6){1'b0}}, idx_q});
    by_s    = {{(WW-7){by_q[6]}}, by_q};
    to_s    = idx_s + by_s;
    cnt_s   = signed'({{(WW-CW){1'b0}}, count});
    idx_ok  = idx_s < cnt_s;
    move_ok = idx_ok && !to_s[WW-1] && (to_s < cnt_s);
    case (cmd_q)
      CMD_ADD: begin
        if (cnt_s >= WW'(RULE_ENTRIES)) code = STAT_FULL;
        else if (tag_q == 16'd0)        code = STAT_NO_TAG;
        else if (plo_q > phi_q)         code = STAT_BAD_RANGE;
        else                            code = STAT_OK;
      end
      CMD_REMOVE, CMD_SETEN, CMD_READ: code = idx_ok ? STAT_OK : STAT_BAD_INDEX;
      CMD_MOVE: code = move_ok ? STAT_OK : STAT_BAD_INDEX;
      default:  code = STAT_OK;
    endcase
  end

  always_comb begin
    hit = rd_q.on && (rd_q.dir == dir_q)
       && (rd_q.proto == PROTO_ANY || proto_q == PROTO_ANY || rd_q.proto == proto_q)
       && ((rd_q.lo == 16'd0 && rd_q.hi == 16'd0)
           || (plo_q >= rd_q.lo && plo_q <= rd_q.hi))
       && (rd_q.prog == 8'd0 || rd_q.prog == prog_q);
  end

  always_comb begin
    sts.cmd        = cmd_q;
    sts.ok         = (code == STAT_OK);
    sts.fw_on      = firewall_on;
    sts.scan_end   = (ptr == count);
    sts.hit        = hit;
    sts.shift_done = (ptr == end_ptr);
    sts.up         = up;
    sts.out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    ptr_step = up ? (ptr + CW'(1)) : (ptr - CW'(1));
    raddr    = (ctrl.rd_sel == RA_NEXT) ? ptr_step[AW-1:0] : ptr[AW-1:0];
    waddr    = (ctrl.wr_sel == WD_NEW) ? count[AW-1:0] : ptr[AW-1:0];
    case (ctrl.wr_sel)
      WD_NEW: begin
        wdata.on    = en_q;
        wdata.dir   = dir_q;
        wdata.proto = proto_q;
        wdata.act   = act_q;
        wdata.prog  = prog_q;
        wdata.lo    = plo_q;
        wdata.hi    = phi_q;
        wdata.tag   = tag_q;
      end
      WD_RD: wdata = rd_q;
      WD_EN: begin
        wdata    = rd_q;
        wdata.on = en_q;
      end
      WD_HOLD: wdata = hold;
      default: wdata = rd_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_wr) mem[waddr] <= wdata;
    if (ctrl.mem_rd) rd_q <= mem[raddr];
    if (ctrl.hold_load) hold <= rd_q;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q   <= command;
      idx_q   <= index;
      by_q    <= move_by;
      en_q    <= enabled;
      dir_q   <= direction;
      proto_q <= protocol;
      plo_q   <= port_low;
      phi_q   <= port_high;
      prog_q  <= program_id;
      act_q   <= allow;
      tag_q   <= rule_tag;
    end
    if (ctrl.ptr_zero)     ptr <= '0;
    else if (ctrl.ptr_idx) ptr <= CW'(idx_q);
    else if (ctrl.ptr_inc) ptr <= ptr + CW'(1);
    else if (ctrl.ptr_dec) ptr <= ptr - CW'(1);
    if (ctrl.end_load) begin
      if (cmd_q == CMD_REMOVE) begin
        end_ptr <= count - CW'(1);
        up      <= 1'b1;
      end else begin
        end_ptr <= CW'(to_s);
        up      <= (to_s > idx_s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.cnt_inc) begin
      count <= count + CW'(1);
    end else if (ctrl.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      firewall_on <= 1'b1;
      default_in  <= 1'b0;
      default_out <= 1'b1;
    end else if (write_enable) begin
      case (reg_index)
        REG_FIREWALL_ON: firewall_on <= write_data;
        REG_DEFAULT_IN:  default_in  <= write_data;
        REG_DEFAULT_OUT: default_out <= write_data;
        default: ;
      endcase
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (ctrl.res_init) begin
      res_status  <= code;
      res_allowed <= (cmd_q == CMD_QUERY) && !firewall_on;
      res_reason  <= REASON_OFF;
      res_index   <= '0;
      res_tag     <= '0;
      res_rule    <= '0;
    end
    if (ctrl.res_hit) begin
      res_allowed <= rd_q.act;
      res_reason  <= REASON_MATCH;
      res_index   <= 6'(ptr);
      res_tag     <= rd_q.tag;
    end
    if (ctrl.res_default) begin
      res_allowed <= dir_q ? default_out : default_in;
      res_reason  <= REASON_DEFAULT;
    end
    if (ctrl.res_read) begin
      res_allowed <= rd_q.act;
      res_index   <= idx_q;
      res_tag     <= rd_q.tag;
      res_rule    <= rd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.post) begin
      status         <= res_status;
      allowed        <= res_allowed;
      reason         <= res_reason;
      match_index    <= res_index;
      match_tag      <= res_tag;
      rule_total     <= 7'(count);
      read_enabled   <= res_rule.on;
      read_direction <= res_rule.dir;
      read_protocol  <= res_rule.proto;
      read_port_low  <= res_rule.lo;
      read_port_high <= res_rule.hi;
      read_program   <= res_rule.prog;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.post) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### tb/testbench.sv
// testbench for first_match_port_rule_filter: directed table then random commands
// depends on frf_pkg and the filter rtl; checks every result against an in-file predictor
`timescale 1ns / 100ps

module testbench;
  import frf_pkg::*;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  index;
    logic [6:0]  move_by;
    logic        enabled;
    logic        direction;
    logic [1:0]  protocol;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [7:0]  program_id;
    logic        allow;
    logic [15:0] rule_tag;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        allowed;
    logic [1:0]  reason;
    logic [5:0]  match_index;
    logic [15:0] match_tag;
    logic [6:0]  rule_total;
    logic        read_enabled;
    logic        read_direction;
    logic [1:0]  read_protocol;
    logic [15:0] read_port_low;
    logic [15:0] read_port_high;
    logic [7:0]  read_program;
  } verdict_t;

  typedef struct {
    cmd_item_t c;
    bit        typed;
    verdict_t  v;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic write_enable = 0;
  logic [1:0] reg_index = '0;
  logic write_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] command = '0;
  logic [5:0] index = '0;
  logic signed [6:0] move_by = '0;
  logic enabled = 0, direction = 0, allow = 0;
  logic [1:0] protocol = '0;
  logic [15:0] port_low = '0, port_high = '0, rule_tag = '0;
  logic [7:0] program_id = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] status;
  logic allowed;
  logic [1:0] reason;
  logic [5:0] match_index;
  logic [15:0] match_tag;
  logic [6:0] rule_total;
  logic read_enabled, read_direction;
  logic [1:0] read_protocol;
  logic [15:0] read_port_low, read_port_high;
  logic [7:0] read_program;

  always #2 clk = ~clk;

  first_match_port_rule_filter u_top (.*);

  rule_t    shadow_rules[64];
  int       shadow_count;
  bit       fw_on, dflt_in, dflt_out;
  verdict_t pending_verdicts[$];
  int       errors = 0;
  int       in_idle_pct = 0, out_idle_pct = 0;
  int       n_sent = 0, n_checked = 0;
  int       n_query_hit = 0, n_moves = 0;

  function automatic bit rule_hits(rule_t r, cmd_item_t c);
    if (!r.on || r.dir != c.direction) return 0;
    if (r.proto != PROTO_ANY && c.protocol != PROTO_ANY && r.proto != c.protocol) return 0;
    if ((r.lo != 0 || r.hi != 0) && (c.port_low < r.lo || c.port_low > r.hi)) return 0;
    if (r.prog != 0 && r.prog != c.program_id) return 0;
    return 1;
  endfunction

  function automatic verdict_t apply_command(cmd_item_t c);
    verdict_t v;
    int by, dest;
    rule_t mv;
    bit idx_ok;
    v = '0;
    by = $signed(c.move_by);
    idx_ok = c.index < shadow_count;
    case (c.command)
      CMD_QUERY: begin
        if (!fw_on) begin
          v.allowed = 1;
          v.reason = REASON_OFF;
        end else begin
          v.allowed = c.direction ? dflt_out : dflt_in;
          v.reason = REASON_DEFAULT;
          for (int i = 0; i < shadow_count; i++)
            if (rule_hits(shadow_rules[i], c)) begin
              v.allowed = shadow_rules[i].act;
              v.reason = REASON_MATCH;
              v.match_index = 6'(i);
              v.match_tag = shadow_rules[i].tag;
              break;
            end
        end
      end
      CMD_ADD: begin
        if (shadow_count >= 64) v.status = STAT_FULL;
        else if (c.rule_tag == 0) v.status = STAT_NO_TAG;
        else if (c.port_low > c.port_high) v.status = STAT_BAD_RANGE;
        else begin
          shadow_rules[shadow_count] = '{c.enabled, c.direction, c.protocol, c.allow,
                                         c.program_id, c.port_low, c.port_high, c.rule_tag};
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (!idx_ok) v.status = STAT_BAD_INDEX;
        else begin
          for (int i = c.index; i + 1 < shadow_count; i++) shadow_rules[i] = shadow_rules[i + 1];
          shadow_count--;
        end
      end
      CMD_SETEN: begin
        if (!idx_ok) v.status = STAT_BAD_INDEX;
        else shadow_rules[c.index].on = c.enabled;
      end
      CMD_MOVE: begin
        dest = int'(c.index) + by;
        if (!idx_ok || dest < 0 || dest >= shadow_count) v.status = STAT_BAD_INDEX;
        else begin
          mv = shadow_rules[c.index];
          if (dest > c.index)
            for (int i = c.index; i < dest; i++) shadow_rules[i] = shadow_rules[i + 1];
          else
            for (int i = c.index; i > dest; i--) shadow_rules[i] = shadow_rules[i - 1];
          shadow_rules[dest] = mv;
        end
      end
      CMD_READ: begin
        if (!idx_ok) v.status = STAT_BAD_INDEX;
        else begin
          v.allowed = shadow_rules[c.index].act;
          v.match_index = c.index;
          v.match_tag = shadow_rules[c.index].tag;
          v.read_enabled = shadow_rules[c.index].on;
          v.read_direction = shadow_rules[c.index].dir;
          v.read_protocol = shadow_rules[c.index].proto;
          v.read_port_low = shadow_rules[c.index].lo;
          v.read_port_high = shadow_rules[c.index].hi;
          v.read_program = shadow_rules[c.index].prog;
        end
      end
      default: ;
    endcase
    v.rule_total = 7'(shadow_count);
    return v;
  endfunction

  task automatic send_command(cmd_item_t c, bit typed = 0, verdict_t tv = '0);
    verdict_t pv;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    pv = apply_command(c);
    if (typed && tv != pv) begin
      $display("%0t typed row disagrees: expected %h predicted %h", $time, tv, pv);
      errors++;
    end
    pending_verdicts.push_back(typed ? tv : pv);
    if (c.command == CMD_QUERY && pv.reason == REASON_MATCH) n_query_hit++;
    if (c.command == CMD_MOVE && pv.status == STAT_OK) n_moves++;
    in_valid <= 1;
    {command, index, move_by, enabled, direction, protocol, port_low, port_high,
     program_id, allow, rule_tag} <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic write_reg(reg_t r, bit val);
    write_enable <= 1;
    reg_index <= r;
    write_data <= val;
    @(posedge clk);
    write_enable <= 0;
    @(posedge clk);
    case (r)
      REG_FIREWALL_ON: fw_on = val;
      REG_DEFAULT_IN:  dflt_in = val;
      default:         dflt_out = val;
    endcase
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst) begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
      if (out_valid && !out_stall) begin
        got = {status, allowed, reason, match_index, match_tag, rule_total, read_enabled,
               read_direction, read_protocol, read_port_low, read_port_high, read_program};
        if (pending_verdicts.size() == 0) begin
          $display("%0t unexpected result %h", $time, got);
          errors++;
        end else begin
          want = pending_verdicts.pop_front();
          n_checked++;
          if (got != want) begin
            $display("%0t mismatch: expected %h actual %h", $time, want, got);
            if (got.status != want.status)
              $display("  status expected %0d actual %0d", want.status, got.status);
            if (got.allowed != want.allowed || got.reason != want.reason)
              $display("  allowed/reason expected %0d/%0d actual %0d/%0d",
                       want.allowed, want.reason, got.allowed, got.reason);
            if (got.match_index != want.match_index || got.match_tag != want.match_tag)
              $display("  match expected %0d/%h actual %0d/%h", want.match_index,
                       want.match_tag, got.match_index, got.match_tag);
            if (got.rule_total != want.rule_total)
              $display("  rule_total expected %0d actual %0d", want.rule_total,
                       got.rule_total);
            errors++;
          end
        end
      end
    end
  end

  function automatic cmd_item_t random_command();
    cmd_item_t c;
    logic [127:0] raw;
    int k;
    raw = {$urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(cmd_item_t)-1:0];
    k = $urandom_range(99);
    if (k < 30) c.command = CMD_QUERY;
    else if (k < 55) c.command = CMD_ADD;
    else if (k < 65) c.command = CMD_REMOVE;
    else if (k < 73) c.command = CMD_SETEN;
    else if (k < 83) c.command = CMD_MOVE;
    else if (k < 95) c.command = CMD_READ;
    else c.command = 3'($urandom_range(7));
    if (c.command != CMD_QUERY && c.command != CMD_ADD) begin
      if ($urandom_range(9) < 8 && shadow_count > 0)
        c.index = 6'($urandom_range(shadow_count - 1));
      if (c.command == CMD_MOVE && $urandom_range(3) != 0)
        c.move_by = 7'($signed($urandom_range(shadow_count + 2)) -
                       $signed(int'(c.index)) - 1);
    end
    if ($urandom_range(2) == 0) c.protocol = 2'($urandom_range(2));
    if ($urandom_range(3) == 0) c.program_id = 8'($urandom_range(3));
    if (c.command == CMD_ADD) begin
      if ($urandom_range(9) != 0 && c.rule_tag == 0) c.rule_tag = 1;
      if ($urandom_range(2) == 0) begin
        c.port_low = 0;
        c.port_high = 0;
      end else if ($urandom_range(9) != 0) begin
        c.port_low = 16'($urandom_range(2000));
        c.port_high = 16'(c.port_low + $urandom_range(3000));
      end
    end else if (c.command == CMD_QUERY && $urandom_range(1) == 0) begin
      c.port_low = 16'($urandom_range(5000));
    end
    return c;
  endfunction

  cmd_item_t q0;
  dir_row_t  directed[$];
  verdict_t  vz;

  function automatic cmd_item_t mk(logic [2:0] cmd, logic [5:0] idx, logic [6:0] by,
                                   logic en, logic d, logic [1:0] p, logic [15:0] lo,
                                   logic [15:0] hi, logic [7:0] prog, logic a,
                                   logic [15:0] tag);
    return '{cmd, idx, by, en, d, p, lo, hi, prog, a, tag};
  endfunction

  initial begin
    fw_on = 1; dflt_in = 0; dflt_out = 1;
    shadow_count = 0;
    vz = '0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // after reset: empty table, default actions, bad indices, rejected adds, then adds, queries, moves
    directed.push_back('{mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{default: '0, reason: REASON_DEFAULT}});
    directed.push_back('{mk(CMD_QUERY, 0, 0, 0, 1, 0, 80, 0, 0, 0, 0), 1,
                         '{default: '0, allowed: 1, reason: REASON_DEFAULT}});
    directed.push_back('{mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{default: '0, status: STAT_BAD_INDEX}});
    directed.push_back('{mk(CMD_REMOVE, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{default: '0, status: STAT_BAD_INDEX}});
    directed.push_back('{mk(CMD_ADD, 0, 0, 1, 0, 1, 0, 0, 0, 1, 0), 1,
                         '{default: '0, status: STAT_NO_TAG}});
    directed.push_back('{mk(CMD_ADD, 0, 0, 1, 0, 1, 9, 8, 0, 1, 5), 1,
                         '{default: '0, status: STAT_BAD_RANGE}});
    directed.push_back('{mk(CMD_ADD, 0, 0, 1, 0, 1, 100, 200, 0, 1, 16'hffff), 1,
                         '{default: '0, rule_total: 1}});
    directed.push_back('{mk(CMD_ADD, 0, 0, 1, 1, 3, 0, 0, 255, 0, 2), 0, vz});
    directed.push_back('{mk(CMD_ADD, 0, 0, 0, 0, 2, 65535, 65535, 7, 1, 3), 0, vz});
    directed.push_back('{mk(CMD_ADD, 0, 0, 1, 0, 0, 0, 65535, 0, 0, 4), 0, vz});
    directed.push_back('{mk(CMD_QUERY, 0, 0, 0, 0, 0, 150, 0, 0, 0, 0), 0, vz});
    directed.push_back('{mk(CMD_QUERY, 0, 0, 0, 1, 3, 1, 0, 255, 0, 0), 0, vz});
    directed.push_back('{mk(CMD_QUERY, 0, 0, 0, 1, 1, 1, 0, 255, 0, 0), 0, vz});
    directed.push_back('{mk(CMD_QUERY, 0, 0, 0, 0, 2, 65535, 0, 7, 0, 0), 0, vz});
    directed.push_back('{mk(CMD_SETEN, 2, 0, 1, 0, 0, 0, 0, 0, 0, 0), 0, vz});
    directed.push_back('{mk(CMD_QUERY, 0, 0, 0, 0, 2, 65535, 0, 7, 0, 0), 0, vz});
    directed.push_back('{mk(CMD_MOVE, 3, 7'h7d, 0, 0, 0, 0, 0, 0, 0, 0), 0, vz});
    directed.push_back('{mk(CMD_MOVE, 0, 7'h3f, 0, 0, 0, 0, 0, 0, 0, 0), 0, vz});
    directed.push_back('{mk(CMD_MOVE, 0, 7'h41, 0, 0, 0, 0, 0, 0, 0, 0), 0, vz});
    directed.push_back('{mk(CMD_MOVE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, vz});
    directed.push_back('{mk(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, vz});
    directed.push_back('{mk(3'd6, 5, 0, 1, 1, 1, 1, 1, 1, 1, 1), 0, vz});
    directed.push_back('{mk(3'd7, 5, 0, 1, 1, 1, 1, 1, 1, 1, 1), 0, vz});
    directed.push_back('{mk(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, vz});
    foreach (directed[i]) send_command(directed[i].c, directed[i].typed, directed[i].v);
    drain();

    // fill to full, then table full reject and end-to-end moves
    while (shadow_count < 64) begin
      q0 = random_command();
      q0.command = CMD_ADD;
      q0.rule_tag = q0.rule_tag | 1;
      q0.port_high = 16'hffff;
      send_command(q0);
    end
    q0.command = CMD_ADD;
    send_command(q0, 1, '{default: '0, status: STAT_FULL, rule_total: 64});
    q0 = random_command();
    q0.command = CMD_MOVE; q0.index = 63; q0.move_by = 7'h41;
    send_command(q0);
    q0.index = 0; q0.move_by = 7'h3f;
    send_command(q0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_FIREWALL_ON, ph != 2);
      write_reg(REG_DEFAULT_IN, ph[0]);
      write_reg(REG_DEFAULT_OUT, ph[1]);
      case (ph)
        0, 1: begin in_idle_pct = 32; out_idle_pct = 58; end
        2, 3: begin in_idle_pct = 58; out_idle_pct = 32; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      for (int n = 0; n < 250; n++) begin
        send_command(random_command());
        if (n == 120 && ph == 4) begin
          in_valid <= 0;
          while (pending_verdicts.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("covered %0d commands, %0d results checked, %0d rule hits, %0d moves",
             n_sent, n_checked, n_query_hit, n_moves);
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("testbench: done, errors");
    $finish;
  end

endmodule
